// ----- sv/hss_pkg.sv -----
// hss_pkg: shared constants and types of the heat stencil sweep unit.
// No dependencies; compiled first.
package hss_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int GRID_W      = 11;
  localparam int LAMBDA_W    = 15;
  localparam int COORD_W     = 10;
  localparam int LAMBDA_FRAC = 16;
  localparam int MIN_GRID    = 3;
  localparam int GRID_RESET  = 1024;

  localparam int OUT_DEPTH   = 16;
  localparam int OUT_PTR_W   = 4;
  localparam int OUT_CNT_W   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE = 2'd0,
    REG_LAMBDA    = 2'd1
  } cfg_reg_t;

  // per-transaction bookkeeping that travels with a sample down the pipe
  typedef struct packed {
    logic               emit;
    logic               two;
    logic               pass;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } hss_tag_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } hss_fifo_stat_t;

endpackage

// ----- sv/hss_intf.sv -----
// Channel interfaces of the heat stencil sweep unit: sample in, result out,
// configuration write. Depends on hss_pkg.
interface hss_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_start;

  modport source (output valid, sample, frame_start, input ready);
  modport sink   (input valid, sample, frame_start, output ready);
endinterface

interface hss_out_if import hss_pkg::*; #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic [COORD_W-1:0]            row;
  logic [COORD_W-1:0]            col;
  logic                          last;

  modport source (output valid, value, row, col, last, input ready);
  modport sink   (input valid, value, row, col, last, output ready);
endinterface

interface hss_cfg_if import hss_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/heat_stencil_sweep_unit.sv -----
// heat_stencil_sweep_unit: one explicit heat-equation time step, 5-point stencil,
// raster-order stream with two line buffers and a window row of cells.
// Depends on hss_pkg, hss_intf, hss_line_ram, hss_win_cell, hss_out_fifo.
//
//  channel | dir | handshake   | payload
//  in_ch   | in  | valid/ready | sample, frame_start
//  out_ch  | out | valid/ready | value, row, col, last
//  cfg_ch  | in  | valid/ready | index, data (ready always high)
//
// One sample per cycle while in_ch.ready is high; each result passes the pipe and
// the result queue on its way to out_ch. Samples of the last grid row yield two
// results, so there the single-result output port sets the pace.
// in_ch.ready drops once 15 results are owed (16-entry result queue).
// Reset (rst_n low, synchronous) clears counters and window and loads config
// defaults; line buffers keep their contents and need no clearing pass.
module heat_stencil_sweep_unit import hss_pkg::*; #(
  parameter int MAX_GRID    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  hss_in_if.sink    in_ch,
  hss_out_if.source out_ch,
  hss_cfg_if.sink   cfg_ch
);

  localparam int CW    = $clog2(MAX_GRID);
  localparam int NW    = (CW + 1 > GRID_W) ? CW + 1 : GRID_W;
  localparam int SW    = SAMPLE_BITS;
  localparam int DW    = SW + 3;
  localparam int PW    = DW + LAMBDA_W + 1;
  localparam int OUT_W = SW + 2 * COORD_W + 1;

  localparam logic signed [PW-1:0] RND   = PW'(1) << (LAMBDA_FRAC - 1);
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // configuration
  logic [GRID_W-1:0]   grid_r;
  logic [LAMBDA_W-1:0] lam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= GRID_W'(GRID_RESET);
      lam_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_GRID_SIZE: grid_r <= cfg_ch.data[GRID_W-1:0];
        REG_LAMBDA:    lam_r  <= cfg_ch.data[LAMBDA_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  logic [NW-1:0] grid_w, n_w;
  assign grid_w = NW'(grid_r);

  always_comb begin
    if (grid_w < NW'(MIN_GRID)) begin
      n_w = NW'(MIN_GRID);
    end else if (grid_w > NW'(MAX_GRID)) begin
      n_w = NW'(MAX_GRID);
    end else begin
      n_w = grid_w;
    end
  end

  // raster position
  logic [CW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0] r_cur, c_cur, east_addr;
  logic          restart, col_last, row_last;
  logic          in_ready, in_acc, out_acc;
  hss_tag_t      tag_cur;
  logic [1:0]    res_cnt;

  assign restart  = in_ch.frame_start || (NW'(row_r) >= n_w) || (NW'(col_r) >= n_w);
  assign r_cur    = restart ? '0 : row_r;
  assign c_cur    = restart ? '0 : col_r;
  assign col_last = (NW'(c_cur) + NW'(1)) >= n_w;
  assign row_last = (NW'(r_cur) + NW'(1)) >= n_w;

  assign east_addr = (c_cur == CW'(MAX_GRID - 1)) ? '0 : c_cur + CW'(1);

  always_comb begin
    col_nxt = c_cur + CW'(1);
    row_nxt = r_cur;
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : r_cur + CW'(1);
    end
  end

  assign tag_cur.emit = (r_cur != '0);
  assign tag_cur.two  = (r_cur != '0) && row_last;
  assign tag_cur.pass = (r_cur == CW'(1)) || (c_cur == '0) || col_last;
  assign tag_cur.row  = COORD_W'(NW'(r_cur) - NW'(1));
  assign tag_cur.col  = COORD_W'(NW'(c_cur));
  assign res_cnt      = 2'(tag_cur.emit) + 2'(tag_cur.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // results owed: queued plus still in the pipe
  logic [OUT_CNT_W-1:0] committed_r, committed_nxt;

  assign in_ready = committed_r <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign committed_nxt = committed_r + (in_acc ? OUT_CNT_W'(res_cnt) : '0)
                         - OUT_CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= '0;
    end else begin
      committed_r <= committed_nxt;
    end
  end

  // line buffers; newer row kept in two banks for the center and east taps
  logic signed [SW-1:0] center_rd, east_rd, older_rd;
  logic                 s1_valid_r;
  logic [CW-1:0]        s1_c_r;
  logic signed [SW-1:0] s1_x_r;
  hss_tag_t             s1_tag_r;

  hss_line_ram #(.DEPTH(MAX_GRID), .WIDTH(SW)) u_newer_c (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (c_cur),
    .wr_data (in_ch.sample),
    .rd_en   (in_acc),
    .rd_addr (c_cur),
    .rd_data (center_rd)
  );

  hss_line_ram #(.DEPTH(MAX_GRID), .WIDTH(SW)) u_newer_e (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (c_cur),
    .wr_data (in_ch.sample),
    .rd_en   (in_acc),
    .rd_addr (east_addr),
    .rd_data (east_rd)
  );

  hss_line_ram #(.DEPTH(MAX_GRID), .WIDTH(SW)) u_older (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_c_r),
    .wr_data (center_rd),
    .rd_en   (in_acc),
    .rd_addr (c_cur),
    .rd_data (older_rd)
  );

  // older-row write lands on the same edge as the next read
  logic                 fwd_hit_r;
  logic signed [SW-1:0] fwd_data_r;
  logic signed [SW-1:0] north1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= in_acc && s1_valid_r && (c_cur == s1_c_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= center_rd;
  end

  assign north1 = fwd_hit_r ? fwd_data_r : older_rd;

  // stage 1: read data ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_c_r   <= c_cur;
      s1_x_r   <= in_ch.sample;
      s1_tag_r <= tag_cur;
    end
  end

  // window row: west takes the previous center
  logic [SW-1:0] west_q, center_q, east_q;

  hss_win_cell #(.WIDTH(SW)) u_cell_west (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_valid_r),
    .sel_nb   (s1_c_r != '0),
    .nb_in    (center_q),
    .fresh_in ('0),
    .q        (west_q)
  );

  hss_win_cell #(.WIDTH(SW)) u_cell_center (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_valid_r),
    .sel_nb   (1'b0),
    .nb_in    (east_q),
    .fresh_in (center_rd),
    .q        (center_q)
  );

  hss_win_cell #(.WIDTH(SW)) u_cell_east (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_valid_r),
    .sel_nb   (1'b0),
    .nb_in    ('0),
    .fresh_in (east_rd),
    .q        (east_q)
  );

  // stage 2: neighbor sum minus four centers
  logic                 s2_valid_r;
  logic signed [SW-1:0] s2_north_r, s2_x_r;
  hss_tag_t             s2_tag_r;
  logic signed [DW-1:0] d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_north_r <= north1;
      s2_x_r     <= s1_x_r;
      s2_tag_r   <= s1_tag_r;
    end
  end

  assign d2 = DW'(s2_north_r) + DW'(s2_x_r) + DW'($signed(west_q)) + DW'($signed(east_q))
              - (DW'($signed(center_q)) <<< 2);

  // stage 3: scale by lambda
  logic                 s3_valid_r;
  logic signed [DW-1:0] s3_d_r;
  logic signed [SW-1:0] s3_center_r, s3_x_r;
  hss_tag_t             s3_tag_r;
  logic signed [PW-1:0] prod3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      s3_d_r      <= d2;
      s3_center_r <= $signed(center_q);
      s3_x_r      <= s2_x_r;
      s3_tag_r    <= s2_tag_r;
    end
  end

  assign prod3 = s3_d_r * $signed({1'b0, lam_r});

  // stage 4: round half up, add, saturate; boundary cells pass the center through
  logic                 s4_valid_r;
  logic signed [PW-1:0] s4_prod_r;
  logic signed [SW-1:0] s4_center_r, s4_x_r;
  hss_tag_t             s4_tag_r;
  logic signed [PW-1:0] rnd4;
  logic signed [DW-1:0] delta4;
  logic signed [DW:0]   sum4;
  logic signed [SW-1:0] sat4, value4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      s4_prod_r   <= prod3;
      s4_center_r <= s3_center_r;
      s4_x_r      <= s3_x_r;
      s4_tag_r    <= s3_tag_r;
    end
  end

  assign rnd4   = s4_prod_r + RND;
  assign delta4 = rnd4[PW-1:LAMBDA_FRAC];
  assign sum4   = (DW+1)'(s4_center_r) + (DW+1)'(delta4);

  always_comb begin
    if (sum4 > (DW+1)'(S_MAX)) begin
      sat4 = S_MAX;
    end else if (sum4 < (DW+1)'(S_MIN)) begin
      sat4 = S_MIN;
    end else begin
      sat4 = sum4[SW-1:0];
    end
  end

  assign value4 = s4_tag_r.pass ? s4_center_r : sat4;

  // result queue
  logic             push_a, push_b;
  logic [OUT_W-1:0] entry_a, entry_b, fifo_rd;
  hss_fifo_stat_t   fifo_stat;

  assign push_a  = s4_valid_r && s4_tag_r.emit;
  assign push_b  = s4_valid_r && s4_tag_r.two;
  assign entry_a = {value4, s4_tag_r.row, s4_tag_r.col, ~s4_tag_r.two};
  assign entry_b = {s4_x_r, s4_tag_r.row + COORD_W'(1), s4_tag_r.col, 1'b1};

  hss_out_fifo #(.WIDTH(OUT_W)) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_a  (push_a),
    .data_a  (entry_a),
    .push_b  (push_b),
    .data_b  (entry_b),
    .pop     (out_acc),
    .rd_data (fifo_rd),
    .stat    (fifo_stat)
  );

  assign out_ch.valid = !fifo_stat.empty;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign {out_ch.value, out_ch.row, out_ch.col, out_ch.last} = fifo_rd;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credit exceeds queue depth");

  a_queue_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.count <= committed_r)
    else $error("queued results exceed owed results");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> ((OUT_CNT_W+1)'(fifo_stat.count) + (OUT_CNT_W+1)'(push_a)
                    + (OUT_CNT_W+1)'(push_b) <= (OUT_CNT_W+1)'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> $past(s1_valid_r))
    else $error("older-row forward without a pending write");

endmodule

// ----- sv/hss_line_ram.sv -----
// hss_line_ram: one-row line buffer, one write and one registered read port.
// Read-before-write on a shared address. No dependencies.
module hss_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/hss_win_cell.sv -----
// hss_win_cell: one tap of the stencil window row; loads from its neighbor
// tap or from a fresh value. No dependencies.
module hss_win_cell #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             sel_nb,
  input  logic [WIDTH-1:0] nb_in,
  input  logic [WIDTH-1:0] fresh_in,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  assign q_nxt = sel_nb ? nb_in : fresh_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- sv/hss_out_fifo.sv -----
// hss_out_fifo: result queue, up to two pushes and one pop per cycle.
// Depends on hss_pkg.
module hss_out_fifo import hss_pkg::*; #(
  parameter int WIDTH = 53
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_a,
  input  logic [WIDTH-1:0] data_a,
  input  logic           push_b,
  input  logic [WIDTH-1:0] data_b,
  input  logic           pop,
  output logic [WIDTH-1:0] rd_data,
  output hss_fifo_stat_t stat
);

  logic [WIDTH-1:0]     mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] count_r, count_nxt;

  // push_b always comes with push_a and lands in the following slot
  assign wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push_a) + OUT_PTR_W'(push_b);
  assign rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
  assign count_nxt  = count_r + OUT_CNT_W'(push_a) + OUT_CNT_W'(push_b) - OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr_r + OUT_PTR_W'(1)] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign rd_data    = mem[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for heat_stencil_sweep_unit. A directed stimulus table, then random
// raster-order grids checked against an in-bench FTCS stencil predictor, with gaps and stalls.
// Depends on hss_pkg, the hss_*_if interfaces and the unit's RTL.
module tb;
  import hss_pkg::*;

  localparam int MAX_GRID       = 1024;
  localparam int SAMPLE_BITS    = 32;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int BIG_PHASE      = 2;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int FROM_MODEL     = -1;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     col;
    logic                   last;
  } cell_t;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] data;
    logic [31:0]           sample;
    logic                  fs;
    int                    n_typed;
    cell_t                 ex0;
    cell_t                 ex1;
  } stim_row_t;

  localparam cell_t NO_CELL = '0;

  logic clk;
  logic rst_n;

  hss_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  hss_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();
  hss_cfg_if                              cfg_ch ();

  heat_stencil_sweep_unit #(
    .MAX_GRID   (MAX_GRID),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  cell_t     owed_cells[$];
  stim_row_t directed[$];
  int        mismatches = 0;
  int        quiet = 0;
  bit        send_gaps;
  bit        recv_stalls;

  // predictor state
  logic [GRID_W-1:0]       grid_reg;
  logic [LAMBDA_W-1:0]     lambda_reg;
  logic signed [31:0]      older_line[MAX_GRID];
  logic signed [31:0]      newer_line[MAX_GRID];
  bit                      older_ok[MAX_GRID];
  bit                      newer_ok[MAX_GRID];
  logic signed [31:0]      win_center;
  bit                      win_ok;
  int                      row_cnt;
  int                      col_cnt;
  cell_t                   step_res[2];
  int                      step_cnt;
  logic [31:0]             prev_sample;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic cell_t mk_cell(input logic [31:0] v, input int r, input int c,
                                    input logic l);
    return '{value: v, row: r[COORD_W-1:0], col: c[COORD_W-1:0], last: l};
  endfunction

  function automatic int eff_grid();
    int n;
    n = grid_reg;
    if (n < MIN_GRID) n = MIN_GRID;
    if (n > MAX_GRID) n = MAX_GRID;
    return n;
  endfunction

  // 1 if the next sample, without frame_start, would emit a cell built from unwritten lines
  function automatic bit cell_unsafe();
    int n;
    int r;
    int c;
    n = eff_grid();
    r = row_cnt;
    c = col_cnt;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    if (r == 0) return 1'b0;
    if (!newer_ok[c]) return 1'b1;
    if (r == 1 || c == 0 || c == n - 1) return 1'b0;
    return !(older_ok[c] && newer_ok[c+1] && win_ok);
  endfunction

  task automatic ftcs_update(input logic signed [31:0] x, input logic fs);
    int     n;
    int     r;
    int     c;
    longint west;
    longint center;
    longint east;
    longint north;
    longint lam;
    longint d;
    longint v;
    n = eff_grid();
    lam = lambda_reg;
    if (fs || row_cnt >= n || col_cnt >= n) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    r = row_cnt;
    c = col_cnt;
    west = 0;
    east = 0;
    if (c > 0) west = win_center;
    center = newer_line[c];
    if (c + 1 < n) east = newer_line[c+1];
    step_cnt = 0;
    if (r > 0) begin
      if (r == 1 || c == 0 || c == n - 1) begin
        v = center;
      end else begin
        north = older_line[c];
        d = north + longint'(x) + west + east - 4 * center;
        v = center + ((d * lam + 64'sd32768) >>> 16);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        else if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      step_res[0] = mk_cell(v[31:0], r - 1, c, r != n - 1);
      step_cnt = 1;
      if (r == n - 1) begin
        step_res[1] = mk_cell(x, r, c, 1'b1);
        step_cnt = 2;
      end
    end
    win_center = center[31:0];
    win_ok = newer_ok[c];
    older_line[c] = newer_line[c];
    older_ok[c] = newer_ok[c];
    newer_line[c] = x;
    newer_ok[c] = 1'b1;
    if (c + 1 >= n) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= n) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  function automatic logic [31:0] next_sample();
    case ($urandom_range(0, 9))
      0, 1: prev_sample = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: prev_sample = S_MAX;
          1: prev_sample = S_MIN;
          2: prev_sample = '0;
          3: prev_sample = '1;
          default: prev_sample = 32'd1;
        endcase
      end
      default: prev_sample = prev_sample + $urandom_range(0, 131072) - 32'd65536;
    endcase
    return prev_sample;
  endfunction

  task automatic send_sample(input logic [31:0] x, input logic fs, input int n_typed,
                             input cell_t ex0, input cell_t ex1);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= x;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ftcs_update(x, fs);
    if (n_typed == FROM_MODEL) begin
      for (int k = 0; k < step_cnt; k++) owed_cells.push_back(step_res[k]);
    end else begin
      if (n_typed > 0) owed_cells.push_back(ex0);
      if (n_typed > 1) owed_cells.push_back(ex1);
    end
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GRID_SIZE: grid_reg = data[GRID_W-1:0];
      REG_LAMBDA:    lambda_reg = data[LAMBDA_W-1:0];
      default: ;
    endcase
  endtask

  // row-zero samples emit nothing, so settle past the pipe latency once the queue drains
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (owed_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t entry;
    entry = '{is_cfg: 1'b1, reg_idx: idx, data: data, sample: '0, fs: 1'b0,
              n_typed: 0, ex0: NO_CELL, ex1: NO_CELL};
    directed.push_back(entry);
  endtask

  task automatic add_smp(input logic [31:0] x, input logic fs, input int n_typed,
                         input cell_t ex0, input cell_t ex1);
    stim_row_t entry;
    entry = '{is_cfg: 1'b0, reg_idx: REG_GRID_SIZE, data: '0, sample: x, fs: fs,
              n_typed: n_typed, ex0: ex0, ex1: ex1};
    directed.push_back(entry);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (recv_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    cell_t got;
    cell_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{value: out_ch.value, row: out_ch.row, col: out_ch.col, last: out_ch.last};
      if (owed_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%t: result with nothing owed, got value=%h row=%0d col=%0d last=%b",
                   $time, got.value, got.row, got.col, got.last);
      end else begin
        want = owed_cells.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 50)
            $display("%t: exp value=%h row=%0d col=%0d last=%b, got value=%h row=%0d col=%0d last=%b",
                     $time, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%t: no transaction for %0d cycles, %0d cells owed",
               $time, quiet, owed_cells.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int                  items;
    int                  phase;
    int                  n;
    int                  frame_len;
    int                  count;
    int                  mode;
    logic [GRID_W-1:0]   grid;
    logic [LAMBDA_W-1:0] lam;
    logic                fs;
    bit                  tail;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.sample      <= '0;
    in_ch.frame_start <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_GRID_SIZE;
    cfg_ch.data       <= '0;
    grid_reg    = GRID_W'(GRID_RESET);
    lambda_reg  = '0;
    row_cnt     = 0;
    col_cnt     = 0;
    win_center  = '0;
    win_ok      = 1'b1;
    prev_sample = '0;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;

    // reset config: row zero only stores
    add_smp(S_MAX, 1'b1, 0, NO_CELL, NO_CELL);
    add_smp(S_MIN, 1'b0, 0, NO_CELL, NO_CELL);
    add_cfg(REG_GRID_SIZE, 16'd3);
    add_cfg(REG_LAMBDA, 16'd16384);
    // 3x3 grid: boundary pass-through, last row emits its own cells
    add_smp(S_MAX, 1'b1, 0, NO_CELL, NO_CELL);
    add_smp(S_MIN, 1'b0, 0, NO_CELL, NO_CELL);
    add_smp(32'd0, 1'b0, 0, NO_CELL, NO_CELL);
    add_smp(32'd5, 1'b0, 1, mk_cell(S_MAX, 0, 0, 1'b1), NO_CELL);
    add_smp(S_MIN, 1'b0, 1, mk_cell(S_MIN, 0, 1, 1'b1), NO_CELL);
    add_smp(32'd7, 1'b0, 1, mk_cell(32'd0, 0, 2, 1'b1), NO_CELL);
    add_smp(32'd1, 1'b0, 2, mk_cell(32'd5, 1, 0, 1'b0), mk_cell(32'd1, 2, 0, 1'b1));
    add_smp(S_MAX, 1'b0, FROM_MODEL, NO_CELL, NO_CELL);
    add_smp('1, 1'b0, 2, mk_cell(32'd7, 1, 2, 1'b0), mk_cell('1, 2, 2, 1'b1));
    // stream runs past the grid and wraps to row zero
    add_smp(32'd11, 1'b0, 0, NO_CELL, NO_CELL);
    add_smp(32'd12, 1'b0, 0, NO_CELL, NO_CELL);
    add_smp(32'd13, 1'b0, 0, NO_CELL, NO_CELL);
    // undersized grid clamps to 3; lambda above nominal saturates the interior cell
    add_cfg(REG_GRID_SIZE, 16'd2);
    add_cfg(REG_LAMBDA, 16'h7fff);
    add_smp(S_MAX, 1'b1, 0, NO_CELL, NO_CELL);
    add_smp(S_MAX, 1'b0, 0, NO_CELL, NO_CELL);
    add_smp(S_MAX, 1'b0, 0, NO_CELL, NO_CELL);
    add_smp(S_MAX, 1'b0, 1, mk_cell(S_MAX, 0, 0, 1'b1), NO_CELL);
    add_smp(S_MIN, 1'b0, 1, mk_cell(S_MAX, 0, 1, 1'b1), NO_CELL);
    add_smp(S_MAX, 1'b0, 1, mk_cell(S_MAX, 0, 2, 1'b1), NO_CELL);
    add_smp(S_MAX, 1'b0, 2, mk_cell(S_MAX, 1, 0, 1'b0), mk_cell(S_MAX, 2, 0, 1'b1));
    add_smp(S_MAX, 1'b0, 2, mk_cell(S_MAX, 1, 1, 1'b0), mk_cell(S_MAX, 2, 1, 1'b1));
    add_smp(S_MAX, 1'b0, 2, mk_cell(S_MAX, 1, 2, 1'b0), mk_cell(S_MAX, 2, 2, 1'b1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        cfg_write(directed[i].reg_idx, directed[i].data);
      end else begin
        send_sample(directed[i].sample, directed[i].fs, directed[i].n_typed,
                    directed[i].ex0, directed[i].ex1);
      end
    end

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) grid = 11'd3;
      else if (phase == BIG_PHASE) grid = 11'd2047;
      else begin
        case ($urandom_range(0, 9))
          0: grid = GRID_W'($urandom_range(0, 2));
          1: grid = GRID_W'($urandom_range(13, 24));
          default: grid = GRID_W'($urandom_range(3, 10));
        endcase
      end
      case ($urandom_range(0, 5))
        0: lam = '0;
        1: lam = 15'd16384;
        2: lam = 15'h7fff;
        3: lam = LAMBDA_W'($urandom_range(0, 16384));
        default: lam = LAMBDA_W'($urandom_range(0, 32767));
      endcase
      if (phase == 0) lam = '0;
      cfg_write(REG_GRID_SIZE, {5'($urandom), grid});
      cfg_write(REG_LAMBDA, {1'($urandom), lam});

      tail = items >= RANDOM_ITEMS * 85 / 100;
      send_gaps = !tail && $urandom_range(0, 2) != 0;
      recv_stalls = !tail && $urandom_range(0, 2) != 0;

      n = eff_grid();
      frame_len = n * n;
      mode = $urandom_range(0, 19);
      if (phase == BIG_PHASE) begin
        mode = 0;
        count = n + 40;
      end else if (mode < 14) begin
        count = frame_len * $urandom_range(1, 2);
      end else begin
        count = $urandom_range(1, 2 * frame_len);
      end
      if (phase != BIG_PHASE && count > RANDOM_ITEMS - items) count = RANDOM_ITEMS - items;

      for (int k = 0; k < count; k++) begin
        if (mode < 14)
          fs = (k == 0) ? 1'b1 : ((k % frame_len == 0) ? 1'($urandom) : 1'b0);
        else if (mode < 17)
          fs = 1'b0;
        else
          fs = ($urandom_range(0, 15) == 0);
        if (!fs && cell_unsafe()) fs = 1'b1;
        send_sample(next_sample(), fs, FROM_MODEL, NO_CELL, NO_CELL);
      end
      items += count;
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hss_pkg.sv
sv/hss_intf.sv
sv/hss_line_ram.sv
sv/hss_win_cell.sv
sv/hss_out_fifo.sv
sv/heat_stencil_sweep_unit.sv
tb/tb.sv
